FILE: sv/pfh_pkg.sv
// ============================================================================
// pfh_pkg: shared types and constants for the program fingerprint hash
// Holds the beat payload structs, the FNV constants and the queue sizing.
// ============================================================================
package pfh_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Work queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] primary_hash;
        logic [31:0] word_hash;
        logic [31:0] byte_length;
        logic [7:0]  xor_checksum;
    } t_out_item;

    // One classified byte as the back part sees it.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        fold_word;
        logic [31:0] word;
    } t_work_item;

endpackage

FILE: sv/pfh_front.sv
// ============================================================================
// pfh_front: input side of the fingerprint hash
// Accepts bytes, assembles little-endian words and marks the bytes that
// close a word, then hands each classified byte to the work queue.
// ============================================================================
module pfh_front import pfh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_in_stall,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_work_item o_push_data
);

    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    logic [31:0] r_asm;
    logic [31:0] n_asm;
    logic [31:0] word;
    logic        fold;
    logic        accept;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    always_comb begin
        word  = r_asm | (32'(i_in_data.data_byte) << {r_pos, 3'b000});
        fold  = (r_pos == 2'd3) || i_in_data.last_byte;
        n_pos = r_pos;
        n_asm = r_asm;
        if (accept) begin
            n_pos = i_in_data.last_byte ? 2'd0 : r_pos + 2'd1;
            n_asm = fold ? 32'd0 : word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
            r_asm <= 32'd0;
        end else begin
            r_pos <= n_pos;
            r_asm <= n_asm;
        end
    end

    assign o_push                = accept;
    assign o_push_data.data_byte = i_in_data.data_byte;
    assign o_push_data.last_byte = i_in_data.last_byte;
    assign o_push_data.fold_word = fold;
    assign o_push_data.word      = word;

endmodule

FILE: sv/pfh_queue.sv
// ============================================================================
// pfh_queue: short work queue between front and back
// A small register FIFO so that either side can stall on its own.
// ============================================================================
module pfh_queue import pfh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_work_item i_push_data,
    output logic       o_full,
    output logic       o_valid,
    output t_work_item o_head,
    input  logic       i_pop
);

    t_work_item             r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: sv/pfh_back.sv
// ============================================================================
// pfh_back: hashing side of the fingerprint hash
// Folds each byte into the byte hash, each closed word into the word hash,
// keeps length and checksum, and registers one result per program.
// ============================================================================
module pfh_back import pfh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_queue_valid,
    input  t_work_item i_queue_head,
    output logic       o_pop,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall
);

    logic [31:0] r_byte_hash;
    logic [31:0] r_word_hash;
    logic [31:0] r_count;
    logic [7:0]  r_csum;
    logic [31:0] n_byte_hash;
    logic [31:0] n_word_hash;
    logic [31:0] n_count;
    logic [7:0]  n_csum;
    logic        r_out_valid;
    t_out_item   r_out_data;
    logic        out_free;
    logic        pop;

    // Only a closing byte needs the result register; others flow past a stall.
    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = i_queue_valid && (!i_queue_head.last_byte || out_free);
    assign o_pop    = pop;

    always_comb begin
        n_byte_hash = (r_byte_hash ^ 32'(i_queue_head.data_byte)) * FNV_PRIME;
        n_word_hash = i_queue_head.fold_word ?
                      (r_word_hash ^ i_queue_head.word) * FNV_PRIME : r_word_hash;
        n_count     = r_count + 32'd1;
        n_csum      = r_csum ^ i_queue_head.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_hash <= FNV_BASIS;
            r_word_hash <= FNV_BASIS;
            r_count     <= 32'd0;
            r_csum      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (i_queue_head.last_byte) begin
                    r_byte_hash <= FNV_BASIS;
                    r_word_hash <= FNV_BASIS;
                    r_count     <= 32'd0;
                    r_csum      <= 8'd0;
                end else begin
                    r_byte_hash <= n_byte_hash;
                    r_word_hash <= n_word_hash;
                    r_count     <= n_count;
                    r_csum      <= n_csum;
                end
            end
            if (pop && i_queue_head.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_queue_head.last_byte) begin
            r_out_data.primary_hash <= n_byte_hash;
            r_out_data.word_hash    <= n_word_hash;
            r_out_data.byte_length  <= n_count;
            r_out_data.xor_checksum <= n_csum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: sv/program_fingerprint_hash.sv
// ============================================================================
// program_fingerprint_hash: FNV-1a program fingerprint
// Hashes a byte stream per byte and per little-endian word, and reports
// both hashes with the byte length and XOR checksum after the last byte.
// ============================================================================
//
//  channel  direction  payload     handshake
//  in       input      t_in_item   i_in_valid / o_in_stall
//  out      output     t_out_item  o_out_valid / i_out_stall
//
//  One byte beat per cycle is taken while o_in_stall is low; the back part
//  folds each byte with its two 32-bit FNV multiplies by a constant.
//  A result is registered and appears in the cycle after its last byte leaves
//  the work queue; that byte goes first into the queue, then into the result register.
//  Synchronous active-low reset returns all running values to start values.
//  An output stall blocks only closing bytes; the four-entry queue absorbs
//  input beats meanwhile, and o_in_stall rises when it is full.
//
module program_fingerprint_hash import pfh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic       queue_full;
    logic       push;
    t_work_item push_data;
    logic       queue_valid;
    t_work_item queue_head;
    logic       pop;

    pfh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    pfh_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .o_valid     (queue_valid),
        .o_head      (queue_head),
        .i_pop       (pop)
    );

    pfh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_valid (queue_valid),
        .i_queue_head  (queue_head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule
